### hw/rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and constants for the vector similarity accumulator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int ELEM_W    = 16;
  localparam int DOT_W     = 44;
  localparam int SQ_W      = 43;
  localparam int DIST_W    = 45;
  localparam int CNT_W     = 13;
  localparam int COS_W     = 32;
  localparam int PROD_W    = 88;
  localparam int MUL_STEPS = 44;
  localparam int DIV_STEPS = 60;
  localparam int SQRT_STEPS = 30;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic [DOT_W-1:0]  dot;
    logic [DIST_W-1:0] dist_sq;
    logic [SQ_W-1:0]   sum_a;
    logic [SQ_W-1:0]   sum_b;
    logic              ovf;
    logic [CNT_W-1:0]  count;
  } vsa_job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } vsa_qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vsa_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } vsa_state_t;

endpackage

### hw/rtl/vsa_front.sv
// ----------------------------------------------------------------------------
// vsa_front
// Accumulates element pairs; a last pair pushes a finished job.
// ----------------------------------------------------------------------------
module vsa_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vsa_pkg::ELEM_W-1:0] in_elem_a,
  input  logic signed [vsa_pkg::ELEM_W-1:0] in_elem_b,
  input  logic                              in_last_element,
  input  vsa_pkg::vsa_qstat_t               q_stat,
  output logic                              q_push,
  output vsa_pkg::vsa_job_t                 q_job
);
  import vsa_pkg::*;

  logic [DOT_W-1:0]  dot_r, dot_nxt;
  logic [SQ_W-1:0]   sa_r, sa_nxt, sb_r, sb_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              xfer;
  logic signed [2*ELEM_W-1:0] pab, paa, pbb;
  logic signed [ELEM_W:0]     diff;
  logic [2*ELEM_W+1:0]        pdd;

  assign in_stall = q_stat.full;
  assign xfer     = in_valid && !in_stall;

  assign pab  = in_elem_a * in_elem_b;
  assign paa  = in_elem_a * in_elem_a;
  assign pbb  = in_elem_b * in_elem_b;
  assign diff = {in_elem_a[ELEM_W-1], in_elem_a} - {in_elem_b[ELEM_W-1], in_elem_b};
  assign pdd  = $unsigned((2*ELEM_W+2)'(diff) * (2*ELEM_W+2)'(diff));

  always_comb begin
    dot_nxt  = dot_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    dist_nxt = dist_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    if (cnt_r < CNT_W'(MAX_DIM)) begin
      dot_nxt  = dot_r + DOT_W'(pab);
      sa_nxt   = sa_r + SQ_W'($unsigned(paa));
      sb_nxt   = sb_r + SQ_W'($unsigned(pbb));
      dist_nxt = dist_r + DIST_W'(pdd);
      cnt_nxt  = cnt_r + 1'b1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign q_push        = xfer && in_last_element;
  assign q_job.dot     = dot_nxt;
  assign q_job.dist_sq = dist_nxt;
  assign q_job.sum_a   = sa_nxt;
  assign q_job.sum_b   = sb_nxt;
  assign q_job.ovf     = ovf_nxt;
  assign q_job.count   = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      dot_r  <= '0;
      sa_r   <= '0;
      sb_r   <= '0;
      dist_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (xfer) begin
      dot_r  <= dot_nxt;
      sa_r   <= sa_nxt;
      sb_r   <= sb_nxt;
      dist_r <= dist_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

### hw/rtl/vsa_queue.sv
// ----------------------------------------------------------------------------
// vsa_queue
// Two-entry job queue between the accumulator and the cosine unit.
// ----------------------------------------------------------------------------
module vsa_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  vsa_pkg::vsa_qctl_t  ctl,
  input  vsa_pkg::vsa_job_t   wr_job,
  output vsa_pkg::vsa_job_t   rd_job,
  output vsa_pkg::vsa_qstat_t stat
);
  import vsa_pkg::*;

  vsa_job_t   mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_job     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (ctl.push) mem_r[wptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (ctl.push) wptr_r <= ~wptr_r;
      if (ctl.pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, ctl.push} - {1'b0, ctl.pop};
    end
  end

endmodule

### hw/rtl/vsa_back.sv
// ----------------------------------------------------------------------------
// vsa_back
// Cosine unit: serial multiplies, restoring divide and square root.
// ----------------------------------------------------------------------------
module vsa_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  vsa_pkg::vsa_qstat_t                    q_stat,
  input  vsa_pkg::vsa_job_t                      q_job,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [vsa_pkg::DOT_W-1:0]       out_dot_product,
  output logic [vsa_pkg::DIST_W-1:0]             out_distance_sq,
  output logic signed [vsa_pkg::COS_W-1:0]       out_cosine,
  output logic                                   out_degenerate,
  output logic                                   out_overflowed,
  output logic [vsa_pkg::CNT_W-1:0]              out_element_count
);
  import vsa_pkg::*;

  vsa_state_t state_r, state_nxt;
  vsa_job_t   job_r;
  logic [STEP_W-1:0] step_r;
  logic [PROD_W-1:0] acc_r, mcand_r, p_r;
  logic [MUL_STEPS-1:0] mplier_r;
  logic [PROD_W:0]   rem_r, rem_sh;
  logic [DIV_STEPS-1:0] quo_r;
  logic [33:0] sq_rem_r, sq_try, sq_t;
  logic [SQRT_STEPS-1:0] root_r;
  logic [COS_W-1:0] cos_r;
  logic [MUL_STEPS-1:0] dmag;
  logic [PROD_W-1:0] acc_add;
  logic dneg, degen, last_step, cap;

  assign dneg  = job_r.dot[DOT_W-1];
  assign dmag  = dneg ? MUL_STEPS'(-job_r.dot) : MUL_STEPS'(job_r.dot);
  assign degen = (q_job.sum_a == '0) || (q_job.sum_b == '0);
  assign acc_add = mplier_r[0] ? acc_r + mcand_r : acc_r;
  assign rem_sh  = {rem_r[PROD_W-1:0], 1'b0};
  assign sq_try  = {sq_rem_r[31:0], quo_r[DIV_STEPS-1 -: 2]};
  assign sq_t    = {2'b00, root_r, 2'b01};
  // magnitude of D*D at or above A*B: cosine saturates at one
  assign cap     = (acc_add >= p_r);

  always_comb begin
    last_step = 1'b0;
    case (state_r)
      ST_MUL_P, ST_MUL_D: last_step = (step_r == STEP_W'(MUL_STEPS - 1));
      ST_DIV:             last_step = (step_r == STEP_W'(DIV_STEPS - 1));
      ST_SQRT:            last_step = (step_r == STEP_W'(SQRT_STEPS - 1));
      default:            last_step = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!q_stat.empty) state_nxt = degen ? ST_OUT : ST_MUL_P;
      ST_MUL_P: if (last_step) state_nxt = ST_MUL_D;
      ST_MUL_D: if (last_step) state_nxt = cap ? ST_OUT : ST_DIV;
      ST_DIV:   if (last_step) state_nxt = ST_SQRT;
      ST_SQRT:  if (last_step) state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == ST_IDLE) && !q_stat.empty;
    out_valid = (state_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    step_r <= last_step ? '0 : step_r + 1'b1;
    case (state_r)
      ST_IDLE: begin
        step_r   <= '0;
        job_r    <= q_job;
        acc_r    <= '0;
        mcand_r  <= PROD_W'(q_job.sum_a);
        mplier_r <= MUL_STEPS'(q_job.sum_b);
        cos_r    <= '0;
      end
      ST_MUL_P, ST_MUL_D: begin
        acc_r    <= acc_add;
        mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
        mplier_r <= mplier_r >> 1;
        if (last_step && state_r == ST_MUL_P) begin
          p_r      <= acc_add;
          acc_r    <= '0;
          mcand_r  <= PROD_W'(dmag);
          mplier_r <= dmag;
        end
        if (last_step && state_r == ST_MUL_D) begin
          rem_r    <= {1'b0, acc_add};
          sq_rem_r <= '0;
          root_r   <= '0;
          if (cap) cos_r <= dneg ? -(COS_W'(1) << 30) : (COS_W'(1) << 30);
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, p_r}) begin
          rem_r <= rem_sh - {1'b0, p_r};
          quo_r <= {quo_r[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[DIV_STEPS-2:0], 1'b0};
        end
      end
      ST_SQRT: begin
        quo_r <= {quo_r[DIV_STEPS-3:0], 2'b00};
        if (sq_try >= sq_t) begin
          sq_rem_r <= sq_try - sq_t;
          root_r   <= {root_r[SQRT_STEPS-2:0], 1'b1};
          if (last_step) cos_r <= dneg ? -COS_W'({root_r[SQRT_STEPS-2:0], 1'b1})
                                       : COS_W'({root_r[SQRT_STEPS-2:0], 1'b1});
        end else begin
          sq_rem_r <= sq_try;
          root_r   <= {root_r[SQRT_STEPS-2:0], 1'b0};
          if (last_step) cos_r <= dneg ? -COS_W'({root_r[SQRT_STEPS-2:0], 1'b0})
                                       : COS_W'({root_r[SQRT_STEPS-2:0], 1'b0});
        end
      end
      default: ;
    endcase
  end

  assign out_dot_product   = job_r.dot;
  assign out_distance_sq   = job_r.dist_sq;
  assign out_cosine        = cos_r;
  assign out_degenerate    = (job_r.sum_a == '0) || (job_r.sum_b == '0);
  assign out_overflowed    = job_r.ovf;
  assign out_element_count = job_r.count;

endmodule

### hw/rtl/vector_similarity_accumulator.sv
// Cosine path: two 44-step serial multiplies, a 60-step divide, a 30-step root;
//   a degenerate job skips all four, a saturating cosine the divide and root.
// Throughput: one pair per cycle while in_stall is low; the serial cosine unit
//   takes one job at a time, and in_stall rises while the two-job queue in
//   front of it is full.
// Reset: synchronous active-low rst_n clears accumulators, queue and FSM.
// ----------------------------------------------------------------------------
// vector_similarity_accumulator
// Dot product, squared distance and cosine similarity of streamed vectors.
// ----------------------------------------------------------------------------
module vector_similarity_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [vsa_pkg::ELEM_W-1:0] in_elem_a,
  input  logic signed [vsa_pkg::ELEM_W-1:0] in_elem_b,
  input  logic                              in_last_element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [vsa_pkg::DOT_W-1:0]  out_dot_product,
  output logic [vsa_pkg::DIST_W-1:0]        out_distance_sq,
  output logic signed [vsa_pkg::COS_W-1:0]  out_cosine,
  output logic                              out_degenerate,
  output logic                              out_overflowed,
  output logic [vsa_pkg::CNT_W-1:0]         out_element_count
);
  import vsa_pkg::*;

  vsa_qctl_t  qctl;
  vsa_qstat_t qstat;
  vsa_job_t   wr_job, rd_job;
  logic       push, pop;

  assign qctl.push = push;
  assign qctl.pop  = pop;

  vsa_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_elem_a, .in_elem_b, .in_last_element,
    .q_stat(qstat), .q_push(push), .q_job(wr_job)
  );

  vsa_queue u_queue (
    .clk, .rst_n, .ctl(qctl), .wr_job(wr_job), .rd_job(rd_job), .stat(qstat)
  );

  vsa_back u_back (
    .clk, .rst_n, .q_stat(qstat), .q_job(rd_job), .q_pop(pop),
    .out_valid, .out_stall, .out_dot_product, .out_distance_sq, .out_cosine,
    .out_degenerate, .out_overflowed, .out_element_count
  );

endmodule
